// File: sv/path_crc32_hex_hash_macros.svh
// Assertion macros for the checker file of the path hash block.
`ifndef PATH_CRC32_HEX_HASH_MACROS_SVH
`define PATH_CRC32_HEX_HASH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define PCHH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pchh assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define PCHH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pchh assertion failed");

`endif

// File: sv/pchh_pkg.sv
// Package for the path hash block: CRC constants, byte normalization, hex encoding.
package pchh_pkg;

  localparam int unsigned DigitCount = 8;
  localparam int unsigned CntW       = $clog2(DigitCount);

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperZ    = 8'h5A;
  localparam logic [7:0] ChCaseBit   = 8'h20;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [3:0] NibTen      = 4'd10;

  // Load request from the CRC stage to the hex emitter
  typedef struct packed {
    logic        valid;
    logic [31:0] crc;
  } emit_load_t;

  // Slash to backslash, ASCII upper case to lower case
  function automatic logic [7:0] norm_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == ChSlash) begin
      r = ChBackslash;
    end else if (b >= ChUpperA && b <= ChUpperZ) begin
      r = b | ChCaseBit;
    end
    return r;
  endfunction

  // One byte into an MSB-first CRC-32, eight bit steps
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Nibble to lower-case ASCII hex digit
  function automatic logic [7:0] to_hex(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < NibTen) begin
      r = ChZero + {4'h0, nib};
    end else begin
      r = ChLowerA + {4'h0, nib - NibTen};
    end
    return r;
  endfunction

endpackage

// File: sv/pchh_in_if.sv
// Path byte channel: valid/ready handshake with one byte of payload.
interface pchh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;

  modport source (output valid, output path_byte, input ready);
  modport sink   (input valid, input path_byte, output ready);
endinterface

// File: sv/pchh_out_if.sv
// Hex digit channel: valid/ready handshake with one ASCII digit and a last flag.
interface pchh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       last_char;

  modport source (output valid, output hex_char, output last_char, input ready);
  modport sink   (input valid, input hex_char, input last_char, output ready);
endinterface

// File: sv/path_crc32_hex_hash.sv
// Path hash top level: normalizes path bytes, folds them into CRC-32/MPEG-2, emits hex.
// Throughput: one path byte per cycle; a terminating NUL sends eight hex digits,
//   one per cycle while the sink is ready, and the next string's bytes fold meanwhile.
// A NUL passes through the input register, then loads the emitter, which then offers
//   its first digit. A second NUL waits in the input register until the
//   emitter has sent the previous hash's last digit.
// Reset: asynchronous, active low; CRC goes to all ones, all stages empty.
module path_crc32_hex_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  pchh_in_if.sink    in_i,
  pchh_out_if.source out_o
);

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic [31:0]          crc_q, crc_d;
  logic                 is_nul;
  logic                 emit_free;
  logic                 advance;
  pchh_pkg::emit_load_t emit_load;

  assign is_nul  = (byte_q == 8'h00);
  // A data byte always moves on; a NUL needs the emitter
  assign advance = in_valid_q && (!is_nul || emit_free);
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.path_byte;
    end
  end

  // CRC update: fold a data byte, restart on NUL
  always_comb begin
    crc_d = crc_q;
    if (advance) begin
      if (is_nul) begin
        crc_d = pchh_pkg::CrcInit;
      end else begin
        crc_d = pchh_pkg::crc_fold(crc_q, pchh_pkg::norm_byte(byte_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= pchh_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign emit_load.valid = in_valid_q && is_nul;
  assign emit_load.crc   = crc_q;

  pchh_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit_load),
    .free_o (emit_free),
    .out_o  (out_o)
  );

endmodule

// File: sv/pchh_emit.sv
// Hex emitter: holds one finished CRC and sends it as eight ASCII digits, MSB first.
module pchh_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pchh_pkg::emit_load_t load_i,
  output logic                free_o,
  pchh_out_if.source          out_o
);

  logic [31:0]               snap_q, snap_d;
  logic [pchh_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      last_dig;
  logic                      xfer;

  assign last_dig = (cnt_q == pchh_pkg::CntW'(pchh_pkg::DigitCount - 1));
  assign xfer     = busy_q && out_o.ready;
  // free now, or the last digit leaves this cycle
  assign free_o   = !busy_q || (xfer && last_dig);

  assign out_o.valid     = busy_q;
  assign out_o.hex_char  = pchh_pkg::to_hex(snap_q[31:28]);
  assign out_o.last_char = last_dig;

  // Next state: load a new hash, or step to the next nibble on a transfer
  always_comb begin
    snap_d = snap_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i.valid && free_o) begin
      snap_d = load_i.crc;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (xfer) begin
      snap_d = {snap_q[27:0], 4'h0};
      cnt_d  = cnt_q + 1'b1;
      busy_d = !last_dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Digit payload, no reset needed
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

endmodule

// File: sv/pchh_checker.sv
// Port-level checker for the path hash block, bound to the top level.
`include "path_crc32_hex_hash_macros.svh"

module pchh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] hex_char_i,
  input logic       last_char_i
);

  logic stall;
  logic digit_ok;
  logic mid_xfer;

  // Digit offered but not taken
  assign stall    = out_valid_i && !out_ready_i;
  // Lower-case ASCII hex digit
  assign digit_ok = (hex_char_i >= 8'h30 && hex_char_i <= 8'h39) ||
                    (hex_char_i >= 8'h61 && hex_char_i <= 8'h66);
  // Transfer of a digit that is not the last of its hash
  assign mid_xfer = out_valid_i && out_ready_i && !last_char_i;

  // A stalled digit holds
  `PCHH_ASSERT_NEXT(a_out_hold, stall, out_valid_i && $stable(hex_char_i) && $stable(last_char_i))

  // Only lower-case hex digits leave the block
  `PCHH_ASSERT_NOW(a_hex_digit, out_valid_i, digit_ok)

  // Digits of one hash come back to back
  `PCHH_ASSERT_NEXT(a_digits_contig, mid_xfer, out_valid_i)

endmodule

bind path_crc32_hex_hash pchh_checker u_pchh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .hex_char_i  (out_o.hex_char),
  .last_char_i (out_o.last_char)
);

// File: dv/tb.sv
// Testbench for the path hash block: directed and random paths checked digit by digit.
module tb;

  localparam logic [31:0] PolyMpeg2    = 32'h04C1_1DB7;
  localparam logic [31:0] SeedAllOnes  = 32'hFFFF_FFFF;
  localparam logic [7:0]  NulChar      = 8'h00;
  localparam logic [7:0]  SlashChar    = 8'h2F;
  localparam logic [7:0]  BackslashChr = 8'h5C;
  localparam logic [7:0]  UpperAChar   = 8'h41;
  localparam logic [7:0]  UpperZChar   = 8'h5A;
  localparam logic [7:0]  DigitZero    = 8'h30;
  localparam logic [7:0]  LowerAChar   = 8'h61;
  localparam int          HoldOffCycles = 60;
  localparam int          SettleCycles  = 20;
  localparam int          CycleLimit    = 200000;
  localparam int          RowCount      = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_flag;
  } hex_digit_t;

  // Directed row: the byte, and for a NUL whose hash is known, that hash
  typedef struct packed {
    logic [7:0]  pbyte;
    logic        typed;
    logic [31:0] hash;
  } path_row_t;

  path_row_t dir_rows [0:RowCount-1] = '{
    '{8'h00, 1'b1, 32'hFFFF_FFFF},  // empty path
    '{8'h00, 1'b1, 32'hFFFF_FFFF},  // empty path again, back to back
    '{8'h31, 1'b0, 32'h0}, '{8'h32, 1'b0, 32'h0}, '{8'h33, 1'b0, 32'h0},
    '{8'h34, 1'b0, 32'h0}, '{8'h35, 1'b0, 32'h0}, '{8'h36, 1'b0, 32'h0},
    '{8'h37, 1'b0, 32'h0}, '{8'h38, 1'b0, 32'h0}, '{8'h39, 1'b0, 32'h0},
    '{8'h00, 1'b1, 32'h0376_E6E7},  // standard check string
    // slash, case-fold edges, neighbors that must pass unchanged, high bytes
    '{8'h2F, 1'b0, 32'h0}, '{8'h41, 1'b0, 32'h0}, '{8'h5A, 1'b0, 32'h0},
    '{8'h40, 1'b0, 32'h0}, '{8'h5B, 1'b0, 32'h0}, '{8'h01, 1'b0, 32'h0},
    '{8'h7F, 1'b0, 32'h0}, '{8'h80, 1'b0, 32'h0}, '{8'hFF, 1'b0, 32'h0},
    '{8'h5C, 1'b0, 32'h0}, '{8'h60, 1'b0, 32'h0}, '{8'h7B, 1'b0, 32'h0},
    '{8'h00, 1'b0, 32'h0}
  };

  logic clk_i;
  logic rst_ni;

  pchh_in_if  path_if ();
  pchh_out_if hex_if ();

  path_crc32_hex_hash uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (path_if),
    .out_o  (hex_if)
  );

  logic [31:0] hash_crc;
  hex_digit_t  digit_q[$];
  int          errors;
  int          bytes_sent;
  int          hashes_queued;
  int          digits_checked;
  int          cycle_count;
  bit          idle_on;
  bit          hold_off_req;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor: slash to backslash, A-Z to lower case
  function automatic logic [7:0] fold_case_and_slash(input logic [7:0] b);
    if (b == SlashChar) return BackslashChr;
    if (b >= UpperAChar && b <= UpperZChar) return b + 8'h20;
    return b;
  endfunction

  // Predictor: one byte into the MSB-first CRC
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ (32'(b) << 24);
    for (int k = 0; k < 8; k++) begin
      c = (c << 1) ^ (c[31] ? PolyMpeg2 : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? DigitZero + 8'(n) : LowerAChar + 8'(n - 4'd10);
  endfunction

  task automatic queue_hash_digits(input logic [31:0] h);
    hex_digit_t d;
    for (int k = 0; k < 8; k++) begin
      d.ch        = nibble_char(h[31 - 4*k -: 4]);
      d.last_flag = (k == 7);
      digit_q     = {digit_q, d};
    end
    hashes_queued++;
  endtask

  // Update the predicted CRC for a transferred byte; a NUL yields its digits
  task automatic note_path_byte(input logic [7:0] b, input logic typed,
                                input logic [31:0] hash);
    bytes_sent++;
    if (b != NulChar) begin
      hash_crc = crc_step(hash_crc, fold_case_and_slash(b));
    end else begin
      queue_hash_digits(typed ? hash : hash_crc);
      hash_crc = SeedAllOnes;
    end
  endtask

  // Offer one byte until it transfers, then maybe leave a gap
  task automatic send_path_byte(input logic [7:0] b, input logic typed,
                                input logic [31:0] hash, input bit may_idle);
    path_if.valid     <= 1'b1;
    path_if.path_byte <= b;
    do @(posedge clk_i); while (!path_if.ready);
    note_path_byte(b, typed, hash);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      path_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Mostly path-like characters, some arbitrary non-zero bytes
  function automatic logic [7:0] random_path_char();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(8'h41, 8'h5A));
      1:       return 8'($urandom_range(8'h61, 8'h7A));
      2:       return SlashChar;
      3:       return BackslashChr;
      4:       return 8'($urandom_range(8'h2D, 8'h3A));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_path(input int len, input bit may_idle);
    for (int i = 0; i < len; i++) begin
      send_path_byte(random_path_char(), 1'b0, 32'h0, may_idle);
    end
    send_path_byte(NulChar, 1'b0, 32'h0, may_idle);
  endtask

  task automatic log_mismatch(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    errors++;
    if (errors <= 10) begin
      $display("tb: mismatch on %s: expected %02h, got %02h at cycle %0d",
               what, exp_v, act_v, cycle_count);
    end
  endtask

  // Digit side ready: random stall bursts, and one long hold-off on request
  initial begin : digit_sink
    hex_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hex_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        hex_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        hex_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Check each digit transfer against the oldest pending expectation
  always @(posedge clk_i) begin : digit_monitor
    hex_digit_t exp_d;
    if (rst_ni && hex_if.valid && hex_if.ready) begin
      if (digit_q.size() == 0) begin
        log_mismatch("digit with nothing pending", 8'h00, hex_if.hex_char);
      end else begin
        exp_d = digit_q.pop_front();
        if (hex_if.hex_char !== exp_d.ch)
          log_mismatch("hex_char", exp_d.ch, hex_if.hex_char);
        if (hex_if.last_char !== exp_d.last_flag)
          log_mismatch("last_char", 8'(exp_d.last_flag), 8'(hex_if.last_char));
        digits_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: timeout with %0d digits pending", digit_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : path_source
    int total;
    hash_crc       = SeedAllOnes;
    errors         = 0;
    bytes_sent     = 0;
    hashes_queued  = 0;
    digits_checked = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;
    hold_off_req   = 1'b0;
    rst_ni            <= 1'b0;
    path_if.valid     <= 1'b0;
    path_if.path_byte <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < RowCount; r++) begin
      send_path_byte(dir_rows[r].pbyte, dir_rows[r].typed, dir_rows[r].hash, 1'b0);
    end

    // Random paths, idling switched per path
    total = bytes_sent;
    while (bytes_sent < total + 35) begin
      idle_on = ($urandom_range(0, 9) < 7);
      send_path($urandom_range(0, 10), idle_on);
    end

    // Sender pause until every digit is out
    path_if.valid <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // Long hold on the digit side while short paths keep coming
    hold_off_req = 1'b1;
    for (int s = 0; s < 5; s++) begin
      send_path($urandom_range(0, 3), 1'b0);
    end

    // One long path
    idle_on = 1'b1;
    send_path(24, 1'b1);

    // Final stretch at full rate on both sides
    idle_on = 1'b0;
    total = bytes_sent;
    while (bytes_sent < total + 25) begin
      send_path($urandom_range(0, 6), 1'b0);
    end
    path_if.valid <= 1'b0;

    while (digit_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("tb: %0d path bytes sent, %0d hashes, %0d hex digits checked",
             bytes_sent, hashes_queued, digits_checked);
    $display("tb: covered case and slash folding, high bytes, empty and long paths, stalls");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
